// ----- rtl/core/ssri_pkg.sv -----
// Shared constants for the sliding SMA / RSI indicator block.
// No dependencies; imported by the indicator top level.
package ssri_pkg;

  // Configuration register width and reset values
  localparam int CFG_W = 11;
  localparam logic [CFG_W-1:0] AVG_LEN_RST = 11'd20;
  localparam logic [CFG_W-1:0] WARMUP_RST  = 11'd15;

  // APB register map: register index sits at byte address bit 2
  localparam int PADDR_W     = 3;
  localparam int APB_DW      = 32;
  localparam int REG_IDX_BIT = 2;
  localparam logic REG_AVG_LEN = 1'b0;
  localparam logic REG_WARMUP  = 1'b1;

  // Port field widths
  localparam int IN_W  = 32;
  localparam int AVG_W = 32;
  localparam int RSI_W = 15;

  // RSI scaling: 100.0 in Q7.8 and 50.0 in Q7.8
  localparam int RSI_K_W   = 16;
  localparam int RSI_BIT_W = 4;
  localparam logic [RSI_K_W-1:0] RSI_SCALE = 16'd25600;
  localparam logic [RSI_W-1:0]   RSI_FULL  = 15'd25600;
  localparam logic [RSI_W-1:0]   RSI_HALF  = 15'd12800;

endpackage

// ----- rtl/core/sliding_sma_rsi_indicator_top.sv -----
// Sliding simple moving average and RSI indicator, top level.
// Uses ssri_pkg, ssri_hist_mem (price ring) and ssri_cmpsub (divider step).
//
// Usage: one closing price word enters on the in_ channel (in_valid/in_stall);
// for every price exactly one result word leaves on the out_ channel
// (out_valid/out_stall) with the held moving average, the held RSI in
// unsigned Q7.8 and a flag that tells whether both were recomputed.
// The user must write the average length and warm-up count over the APB
// port at 0x0 and 0x4 only while the block is idle; the block does not enforce it.
// A price that updates the indicators is first scanned: n ring reads, where n
// is the longer of the average length and RSI_LENGTH + 1 over the windows
// that are full (no reads when neither is). Then the average divide runs
// over WS_W = PRICE_BITS + log2(HISTORY_DEPTH) quotient bits if the average is
// due, and the RSI divide over RSI_K_W bits if an RSI divide is due. A price
// that does not update goes straight to the output. The result word becomes
// valid in the same cycle as the next price can be taken. The window scan
// reads the single ring port once per cycle, the average divide takes one
// quotient bit per cycle and the RSI divide a shift phase and an add phase
// per bit, all through the same compare-subtract unit. in_stall is high while
// a price is in work. A finished word waits in the output register while
// out_stall is high; the next price is taken in the meantime.
// Reset: registers back to 20 and 15, history empty, RSI 50.0, average 0;
// no clearing pass, the ring is read only where it was written.
module sliding_sma_rsi_indicator_top
  import ssri_pkg::*;
#(
  parameter int HISTORY_DEPTH = 1024,
  parameter int RSI_LENGTH    = 14,
  parameter int PRICE_BITS    = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [IN_W-1:0]    in_close_price,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [AVG_W-1:0]   out_moving_average,
  output logic [RSI_W-1:0]   out_rsi_value,
  output logic               out_updated,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [APB_DW-1:0]  pwdata,
  output logic [APB_DW-1:0]  prdata,
  output logic               pready
);

  localparam int AW    = $clog2(HISTORY_DEPTH);
  localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
  localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int WS_W  = PRICE_BITS + AW;
  localparam int RS_W  = PRICE_BITS + $clog2(RSI_LENGTH);
  localparam int REM_W = (RS_W > CFG_W) ? RS_W : CFG_W;
  localparam int U_W   = REM_W + 1;
  localparam int DS_W  = $clog2(WS_W);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SCAN   = 3'd1;
  localparam logic [2:0] ST_MADIV  = 3'd2;
  localparam logic [2:0] ST_RSIDIV = 3'd3;
  localparam logic [2:0] ST_DONE   = 3'd4;

  // Control state
  logic [2:0]       state_r, state_nxt;
  logic [AW-1:0]    wp_r, wp_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             rd_v_r, rd_v_nxt;
  logic [CFG_W-1:0] ma_r, warm_r;
  logic             out_valid_r, out_valid_nxt;
  logic [AVG_W-1:0] avg_r, avg_nxt;
  logic [RSI_W-1:0] rsi_r, rsi_nxt;

  // Datapath registers
  logic [AW-1:0]         rp_r, rp_nxt;
  logic [CNT_W-1:0]      iss_k_r, iss_k_nxt;
  logic [CNT_W-1:0]      n_r, n_nxt;
  logic [CNT_W-1:0]      rd_k_r, rd_k_nxt;
  logic [PRICE_BITS-1:0] prev_r, prev_nxt;
  logic [WS_W-1:0]       wsum_r, wsum_nxt;
  logic [RS_W-1:0]       gain_r, gain_nxt;
  logic [RS_W-1:0]       loss_r, loss_nxt;
  logic [RS_W-1:0]       s_r, s_nxt;
  logic [REM_W-1:0]      rem_r, rem_nxt;
  logic [DS_W-1:0]       step_r, step_nxt;
  logic [RSI_BIT_W-1:0]  bit_r, bit_nxt;
  logic                  ph_r, ph_nxt;
  logic                  upd_r, upd_nxt;
  logic                  ma_ok_r, ma_ok_nxt;
  logic                  rsi_ok_r, rsi_ok_nxt;
  logic                  rsi_div_r, rsi_div_nxt;
  logic [AVG_W-1:0]      out_avg_r, out_avg_nxt;
  logic [RSI_W-1:0]      out_rsi_r, out_rsi_nxt;
  logic                  out_upd_r, out_upd_nxt;

  // Combinational helpers
  logic                  in_acc;
  logic                  cfg_wr;
  logic [PRICE_BITS-1:0] price_w;
  logic [CNT_W-1:0]      cnt_inc;
  logic [CMP_W-1:0]      n_w;
  logic                  ma_ok_w, rsi_ok_w;
  logic                  mem_rd_en;
  logic [PRICE_BITS-1:0] mem_rd_data;
  logic [PRICE_BITS-1:0] diff_up, diff_dn;
  logic [U_W-1:0]        cu_x, cu_d, cu_y;
  logic                  cu_c;

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign price_w  = PRICE_BITS'(in_close_price);
  assign cnt_inc  = (count_r < CNT_W'(HISTORY_DEPTH)) ? (count_r + 1'b1) : count_r;
  assign ma_ok_w  = (ma_r != '0) && (CMP_W'(cnt_inc) >= CMP_W'(ma_r));
  assign rsi_ok_w = CMP_W'(cnt_inc) >= CMP_W'(RSI_LENGTH + 1);
  assign diff_up  = prev_r - mem_rd_data;
  assign diff_dn  = mem_rd_data - prev_r;

  // Scan length: the longer of the windows that are full
  always_comb begin
    n_w = ma_ok_w ? CMP_W'(ma_r) : '0;
    if (rsi_ok_w && (CMP_W'(RSI_LENGTH + 1) > n_w)) begin
      n_w = CMP_W'(RSI_LENGTH + 1);
    end
  end

  ssri_hist_mem #(
    .DEPTH (HISTORY_DEPTH),
    .WIDTH (PRICE_BITS)
  ) u_hist (
    .clk     (clk),
    .wr_en   (in_acc),
    .wr_addr (wp_r),
    .wr_data (price_w),
    .rd_en   (mem_rd_en),
    .rd_addr (rp_r),
    .rd_data (mem_rd_data)
  );

  ssri_cmpsub #(
    .W (U_W)
  ) u_cmpsub (
    .x (cu_x),
    .d (cu_d),
    .y (cu_y),
    .c (cu_c)
  );

  // Sequencer: scan the ring, then run the divisions that are due on the shared unit
  always_comb begin
    state_nxt     = state_r;
    wp_nxt        = wp_r;
    count_nxt     = count_r;
    rd_v_nxt      = rd_v_r;
    avg_nxt       = avg_r;
    rsi_nxt       = rsi_r;
    rp_nxt        = rp_r;
    iss_k_nxt     = iss_k_r;
    n_nxt         = n_r;
    rd_k_nxt      = rd_k_r;
    prev_nxt      = prev_r;
    wsum_nxt      = wsum_r;
    gain_nxt      = gain_r;
    loss_nxt      = loss_r;
    s_nxt         = s_r;
    rem_nxt       = rem_r;
    step_nxt      = step_r;
    bit_nxt       = bit_r;
    ph_nxt        = ph_r;
    upd_nxt       = upd_r;
    ma_ok_nxt     = ma_ok_r;
    rsi_ok_nxt    = rsi_ok_r;
    rsi_div_nxt   = rsi_div_r;
    out_avg_nxt   = out_avg_r;
    out_rsi_nxt   = out_rsi_r;
    out_upd_nxt   = out_upd_r;
    out_valid_nxt = out_valid_r;
    mem_rd_en     = 1'b0;
    cu_x          = '0;
    cu_d          = '0;

    // Drop the output word once taken
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          wp_nxt     = (wp_r == AW'(HISTORY_DEPTH - 1)) ? '0 : (wp_r + 1'b1);
          count_nxt  = cnt_inc;
          rp_nxt     = wp_r;
          iss_k_nxt  = '0;
          rd_v_nxt   = 1'b0;
          wsum_nxt   = '0;
          gain_nxt   = '0;
          loss_nxt   = '0;
          upd_nxt    = CMP_W'(cnt_inc) >= CMP_W'(warm_r);
          ma_ok_nxt  = ma_ok_w;
          rsi_ok_nxt = rsi_ok_w;
          n_nxt      = n_w[CNT_W-1:0];
          state_nxt  = upd_nxt ? ST_SCAN : ST_DONE;
        end
      end
      ST_SCAN: begin
        // Issue one read per cycle, newest price first
        if (iss_k_r != n_r) begin
          mem_rd_en = 1'b1;
          rp_nxt    = (rp_r == '0) ? AW'(HISTORY_DEPTH - 1) : (rp_r - 1'b1);
          iss_k_nxt = iss_k_r + 1'b1;
        end
        rd_v_nxt = (iss_k_r != n_r);
        rd_k_nxt = iss_k_r;
        if (rd_v_r) begin
          // Accumulate the average window
          if (ma_ok_r && (CMP_W'(rd_k_r) < CMP_W'(ma_r))) begin
            wsum_nxt = wsum_r + WS_W'(mem_rd_data);
          end
          // Accumulate gains and losses against the next newer price
          if (rsi_ok_r && (CMP_W'(rd_k_r) <= CMP_W'(RSI_LENGTH))) begin
            if (rd_k_r != '0) begin
              if (prev_r > mem_rd_data) begin
                gain_nxt = gain_r + RS_W'(diff_up);
              end else begin
                loss_nxt = loss_r + RS_W'(diff_dn);
              end
            end
            prev_nxt = mem_rd_data;
          end
        end else if (iss_k_r == n_r) begin
          // Window done: settle the special cases, prepare the divides
          s_nxt       = gain_r + loss_r;
          avg_nxt     = '0;
          rem_nxt     = '0;
          step_nxt    = DS_W'(WS_W - 1);
          bit_nxt     = RSI_BIT_W'(RSI_K_W - 1);
          ph_nxt      = 1'b0;
          rsi_div_nxt = rsi_ok_r && (loss_r != '0);
          if (!rsi_ok_r) begin
            rsi_nxt = RSI_HALF;
          end else if (loss_r == '0) begin
            rsi_nxt = RSI_FULL;
          end else begin
            rsi_nxt = '0;
          end
          if (ma_ok_r) begin
            state_nxt = ST_MADIV;
          end else if (rsi_div_nxt) begin
            state_nxt = ST_RSIDIV;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_MADIV: begin
        // Restoring division of the window sum by the average length, one bit a cycle
        cu_x     = {rem_r, wsum_r[WS_W-1]};
        cu_d     = U_W'(ma_r);
        rem_nxt  = cu_y[REM_W-1:0];
        avg_nxt  = {avg_r[AVG_W-2:0], cu_c};
        wsum_nxt = wsum_r << 1;
        step_nxt = step_r - 1'b1;
        if (step_r == '0) begin
          rem_nxt   = '0;
          state_nxt = rsi_div_r ? ST_RSIDIV : ST_DONE;
        end
      end
      ST_RSIDIV: begin
        // Scaled ratio 25600*G/(G+L): shift phase, then add phase per bit
        cu_d = U_W'(s_r);
        if (!ph_r) begin
          cu_x    = {rem_r, 1'b0};
          rsi_nxt = {rsi_r[RSI_W-2:0], 1'b0} + RSI_W'(cu_c);
        end else begin
          cu_x    = U_W'(rem_r) + (RSI_SCALE[bit_r] ? U_W'(gain_r) : '0);
          rsi_nxt = rsi_r + RSI_W'(cu_c);
        end
        rem_nxt = cu_y[REM_W-1:0];
        ph_nxt  = !ph_r;
        if (ph_r) begin
          bit_nxt = bit_r - 1'b1;
          if (bit_r == '0) begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        // Hand the word to the output register once it is free
        if (!out_valid_r || !out_stall) begin
          out_avg_nxt   = avg_r;
          out_rsi_nxt   = rsi_r;
          out_upd_nxt   = upd_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control and held-indicator registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wp_r        <= '0;
      count_r     <= '0;
      rd_v_r      <= 1'b0;
      avg_r       <= '0;
      rsi_r       <= RSI_HALF;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      count_r     <= count_nxt;
      rd_v_r      <= rd_v_nxt;
      avg_r       <= avg_nxt;
      rsi_r       <= rsi_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    rp_r      <= rp_nxt;
    iss_k_r   <= iss_k_nxt;
    n_r       <= n_nxt;
    rd_k_r    <= rd_k_nxt;
    prev_r    <= prev_nxt;
    wsum_r    <= wsum_nxt;
    gain_r    <= gain_nxt;
    loss_r    <= loss_nxt;
    s_r       <= s_nxt;
    rem_r     <= rem_nxt;
    step_r    <= step_nxt;
    bit_r     <= bit_nxt;
    ph_r      <= ph_nxt;
    upd_r     <= upd_nxt;
    ma_ok_r   <= ma_ok_nxt;
    rsi_ok_r  <= rsi_ok_nxt;
    rsi_div_r <= rsi_div_nxt;
    out_avg_r <= out_avg_nxt;
    out_rsi_r <= out_rsi_nxt;
    out_upd_r <= out_upd_nxt;
  end

  // Configuration registers
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ma_r   <= AVG_LEN_RST;
      warm_r <= WARMUP_RST;
    end else if (cfg_wr) begin
      unique case (paddr[REG_IDX_BIT])
        REG_AVG_LEN: ma_r   <= pwdata[CFG_W-1:0];
        REG_WARMUP:  warm_r <= pwdata[CFG_W-1:0];
        default:     ma_r   <= ma_r;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[REG_IDX_BIT])
      REG_AVG_LEN: prdata = APB_DW'(ma_r);
      REG_WARMUP:  prdata = APB_DW'(warm_r);
      default:     prdata = '0;
    endcase
  end

  assign pready             = 1'b1;
  assign out_valid          = out_valid_r;
  assign out_moving_average = out_avg_r;
  assign out_rsi_value      = out_rsi_r;
  assign out_updated        = out_upd_r;

`ifndef SYNTH
  // An accepted price either scans the history or goes straight to output
  a_accept_next: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == ST_SCAN || state_r == ST_DONE))
    else $error("accepted price did not start a scan or finish");

  // The scan never issues more reads than the window needs
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN |-> iss_k_r <= n_r)
    else $error("window scan overran its length");

  // The RSI remainder always stays below the divisor
  a_rsi_rem: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_RSIDIV |-> U_W'(rem_r) < U_W'(s_r))
    else $error("RSI divider remainder out of range");

  // Held RSI never exceeds 100.0 between prices
  a_rsi_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> rsi_r <= RSI_FULL)
    else $error("held RSI above full scale");

  // History fill count saturates at the ring depth
  a_count_sat: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(HISTORY_DEPTH))
    else $error("price count beyond history depth");
`endif

endmodule

// ----- rtl/core/ssri_hist_mem.sv -----
// Price history ring: single write port, single registered read port.
// Depends on nothing; instantiated by the indicator top level.
module ssri_hist_mem #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write the newest price
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/core/ssri_cmpsub.sv -----
// Shared compare-and-subtract step used by both long divisions.
// Depends on nothing; instantiated by the indicator top level.
module ssri_cmpsub #(
  parameter int W = 38
) (
  input  logic [W-1:0] x,
  input  logic [W-1:0] d,
  output logic [W-1:0] y,
  output logic         c
);

  // Subtract the divisor when it fits, flag the quotient bit
  assign c = (x >= d);
  assign y = c ? (x - d) : x;

endmodule
